// ----- rtl/core/obpk_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obpk_pkg
// Shared constants and helpers for the occupancy box and mask packer.
// ----------------------------------------------------------------------------
package obpk_pkg;

    // map layout: rows always use a stride of eight bits
    localparam int MAP_W         = 64;
    localparam int ROW_STRIDE    = 8;
    localparam int GRID_SIDE_DEF = 8;

    // field widths
    localparam int TYPE_W  = 16;
    localparam int POS_W   = 3;
    localparam int SPAN_W  = 4;
    localparam int OFF_W   = 6;
    localparam int AREA_W  = 7;
    localparam int BYTES_W = 9;

    // liquid type that carries no float heights
    localparam logic [TYPE_W-1:0] NO_FLOAT_TYPE = 16'd2;

    // cells of the map that belong to a grid of the given side
    function automatic logic [MAP_W-1:0] grid_mask(input int side);
        logic [MAP_W-1:0] m;
        m = '0;
        for (int z = 0; z < side; z++) begin
            for (int x = 0; x < side; x++) begin
                m[z*ROW_STRIDE+x] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/obpk_pack.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// obpk_pack
// Two-stage compactor: aligns the box rows, then places them row-major
// from bit zero of the packed mask.
// ----------------------------------------------------------------------------
module obpk_pack #(
    parameter int GRID_SIDE = obpk_pkg::GRID_SIDE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic [obpk_pkg::MAP_W-1:0]       i_map,
    input  wire logic [obpk_pkg::POS_W-1:0]       i_lo_x,
    input  wire logic [obpk_pkg::POS_W-1:0]       i_lo_z,
    input  wire logic [obpk_pkg::SPAN_W-1:0]      i_width,
    input  wire logic                             i_keep,
    output logic      [obpk_pkg::MAP_W-1:0]       o_packed
);

    logic [obpk_pkg::MAP_W-1:0]  shifted;
    logic [GRID_SIDE-1:0]        n_row [GRID_SIDE];
    logic [obpk_pkg::OFF_W-1:0]  n_off [GRID_SIDE];
    logic [GRID_SIDE-1:0]        r_row [GRID_SIDE];
    logic [obpk_pkg::OFF_W-1:0]  r_off [GRID_SIDE];
    logic                        r_keep;
    logic [obpk_pkg::MAP_W-1:0]  n_packed;

    // drop rows below the box, then columns left of it; cells beyond the
    // box edge are empty by definition of the box
    always_comb begin
        shifted = i_map >> {i_lo_z, 3'b000};
        for (int r = 0; r < GRID_SIDE; r++) begin
            n_row[r] = shifted[r*obpk_pkg::ROW_STRIDE +: GRID_SIDE] >> i_lo_x;
            n_off[r] = obpk_pkg::OFF_W'(r * int'(i_width));
        end
    end

    // aligned rows and their target offsets
    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_off  <= n_off;
        r_keep <= i_keep;
    end

    // place each row at row index times box width
    always_comb begin
        n_packed = '0;
        for (int r = 0; r < GRID_SIDE; r++) begin
            n_packed = n_packed |
                ({{(obpk_pkg::MAP_W-GRID_SIDE){1'b0}}, r_row[r]} << r_off[r]);
        end
        if (!r_keep) begin
            n_packed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        o_packed <= n_packed;
    end

endmodule
`default_nettype wire

// ----- rtl/core/occupancy_box_and_mask_pack.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// occupancy_box_and_mask_pack
// Bounding box, fill flags, packed mask and height-map size of an
// occupancy grid.
// ----------------------------------------------------------------------------
// Fully pipelined: one map is taken on every cycle that start is high, and
// busy never rises. Each map gives exactly one result, shown with o_strobe
// for a single cycle; the receiver must take it then. The four register
// stages are grid masking and row/column reduction, box edge search, row
// alignment and row placement.
module occupancy_box_and_mask_pack #(
    parameter int GRID_SIDE = obpk_pkg::GRID_SIDE_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [obpk_pkg::MAP_W-1:0]          i_occupancy,
    input  wire logic [obpk_pkg::TYPE_W-1:0]         i_liquid_type,
    output logic                                     o_strobe,
    output logic      [obpk_pkg::POS_W-1:0]          o_box_x,
    output logic      [obpk_pkg::POS_W-1:0]          o_box_z,
    output logic      [obpk_pkg::SPAN_W-1:0]         o_box_width,
    output logic      [obpk_pkg::SPAN_W-1:0]         o_box_height,
    output logic                                     o_all_filled,
    output logic                                     o_grid_empty,
    output logic                                     o_mask_present,
    output logic      [obpk_pkg::MAP_W-1:0]          o_packed_mask,
    output logic      [obpk_pkg::BYTES_W-1:0]        o_heightmap_bytes
);

    localparam logic [obpk_pkg::MAP_W-1:0] GRID_MASK = obpk_pkg::grid_mask(GRID_SIDE);

    // stage 1
    logic                           r1_vld;
    logic [obpk_pkg::MAP_W-1:0]     r1_map;
    logic [GRID_SIDE-1:0]           r1_rows;
    logic [GRID_SIDE-1:0]           r1_cols;
    logic                           r1_full;
    logic                           r1_depth_only;
    logic [obpk_pkg::MAP_W-1:0]     n1_map;
    logic [GRID_SIDE-1:0]           n1_rows;
    logic [GRID_SIDE-1:0]           n1_cols;

    // stage 2
    logic                           r2_vld;
    logic [obpk_pkg::MAP_W-1:0]     r2_map;
    logic [obpk_pkg::POS_W-1:0]     r2_lo_x;
    logic [obpk_pkg::POS_W-1:0]     r2_lo_z;
    logic [obpk_pkg::SPAN_W-1:0]    r2_w;
    logic [obpk_pkg::SPAN_W-1:0]    r2_h;
    logic                           r2_full;
    logic                           r2_any;
    logic                           r2_depth_only;
    logic [obpk_pkg::POS_W-1:0]     n2_lo_x;
    logic [obpk_pkg::POS_W-1:0]     n2_lo_z;
    logic [obpk_pkg::SPAN_W-1:0]    n2_hi_x;
    logic [obpk_pkg::SPAN_W-1:0]    n2_hi_z;
    logic                           n2_any;

    // stage 3
    logic                           r3_vld;
    logic [obpk_pkg::POS_W-1:0]     r3_lo_x;
    logic [obpk_pkg::POS_W-1:0]     r3_lo_z;
    logic [obpk_pkg::SPAN_W-1:0]    r3_w;
    logic [obpk_pkg::SPAN_W-1:0]    r3_h;
    logic                           r3_full;
    logic                           r3_any;
    logic                           r3_depth_only;
    logic [obpk_pkg::AREA_W-1:0]    r3_area;
    logic [obpk_pkg::BYTES_W-1:0]   n4_bytes;

    assign busy = 1'b0;

    // keep grid cells only and reduce them per row and per column
    always_comb begin
        n1_map  = i_occupancy & GRID_MASK;
        n1_rows = '0;
        n1_cols = '0;
        for (int z = 0; z < GRID_SIDE; z++) begin
            for (int x = 0; x < GRID_SIDE; x++) begin
                n1_rows[z] = n1_rows[z] | n1_map[z*obpk_pkg::ROW_STRIDE+x];
                n1_cols[x] = n1_cols[x] | n1_map[z*obpk_pkg::ROW_STRIDE+x];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start;
        end
        r1_map        <= n1_map;
        r1_rows       <= n1_rows;
        r1_cols       <= n1_cols;
        r1_full       <= (n1_map == GRID_MASK);
        r1_depth_only <= (i_liquid_type == obpk_pkg::NO_FLOAT_TYPE);
    end

    // box edges: first and one past last occupied row and column
    always_comb begin
        n2_lo_x = '0;
        n2_lo_z = '0;
        n2_hi_x = '0;
        n2_hi_z = '0;
        for (int i = GRID_SIDE - 1; i >= 0; i--) begin
            if (r1_cols[i]) begin
                n2_lo_x = obpk_pkg::POS_W'(i);
            end
            if (r1_rows[i]) begin
                n2_lo_z = obpk_pkg::POS_W'(i);
            end
        end
        for (int i = 0; i < GRID_SIDE; i++) begin
            if (r1_cols[i]) begin
                n2_hi_x = obpk_pkg::SPAN_W'(i + 1);
            end
            if (r1_rows[i]) begin
                n2_hi_z = obpk_pkg::SPAN_W'(i + 1);
            end
        end
        n2_any = |r1_rows;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_map        <= r1_map;
        r2_lo_x       <= n2_lo_x;
        r2_lo_z       <= n2_lo_z;
        // an empty grid has both edges at zero, so spans come out zero
        r2_w          <= n2_hi_x - {1'b0, n2_lo_x};
        r2_h          <= n2_hi_z - {1'b0, n2_lo_z};
        r2_full       <= r1_full;
        r2_any        <= n2_any;
        r2_depth_only <= r1_depth_only;
    end

    // mask compaction over stages three and four
    obpk_pack #(
        .GRID_SIDE (GRID_SIDE)
    ) u_pack (
        .i_clk    (i_clk),
        .i_map    (r2_map),
        .i_lo_x   (r2_lo_x),
        .i_lo_z   (r2_lo_z),
        .i_width  (r2_w),
        .i_keep   (r2_any & ~r2_full),
        .o_packed (o_packed_mask)
    );

    // height-map vertex count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_lo_x       <= r2_lo_x;
        r3_lo_z       <= r2_lo_z;
        r3_w          <= r2_w;
        r3_h          <= r2_h;
        r3_full       <= r2_full;
        r3_any        <= r2_any;
        r3_depth_only <= r2_depth_only;
        r3_area       <= ({{(obpk_pkg::AREA_W-obpk_pkg::SPAN_W){1'b0}}, r2_w}
                          + obpk_pkg::AREA_W'(1))
                       * ({{(obpk_pkg::AREA_W-obpk_pkg::SPAN_W){1'b0}}, r2_h}
                          + obpk_pkg::AREA_W'(1));
    end

    // bytes per vertex: five with float heights, one for depth only; none for an empty grid
    always_comb begin
        if (!r3_any) begin
            n4_bytes = '0;
        end else if (r3_depth_only) begin
            n4_bytes = {2'b00, r3_area};
        end else begin
            n4_bytes = {r3_area, 2'b00} + {2'b00, r3_area};
        end
    end

    // output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r3_vld;
        end
        o_box_x           <= r3_lo_x;
        o_box_z           <= r3_lo_z;
        o_box_width       <= r3_w;
        o_box_height      <= r3_h;
        o_all_filled      <= r3_full;
        o_grid_empty      <= ~r3_any;
        // a box around set cells always holds one, so the mask is non-zero
        o_mask_present    <= r3_any & ~r3_full;
        o_heightmap_bytes <= n4_bytes;
    end

endmodule
`default_nettype wire

// ----- bench/tb_occupancy_box_and_mask_pack.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_occupancy_box_and_mask_pack
// Self-checking bench for the occupancy box and mask packer. Directed maps
// cover the empty and full grids, corners, edges and the depth-only liquid
// type. Random maps follow: random boxes with random fill density, sparse and
// near-full grids, and raw 64-bit noise. Each result beat is compared field
// by field against an in-bench model of the box search and mask packing.
// ----------------------------------------------------------------------------
module tb_occupancy_box_and_mask_pack;

    localparam int MAP_W            = obpk_pkg::MAP_W;
    localparam int TYPE_W           = obpk_pkg::TYPE_W;
    localparam int POS_W            = obpk_pkg::POS_W;
    localparam int SPAN_W           = obpk_pkg::SPAN_W;
    localparam int BYTES_W          = obpk_pkg::BYTES_W;
    localparam int ROW_STRIDE       = obpk_pkg::ROW_STRIDE;
    localparam logic [TYPE_W-1:0] NO_FLOAT_TYPE = obpk_pkg::NO_FLOAT_TYPE;
    localparam int GRID_SIDE        = obpk_pkg::GRID_SIDE_DEF;
    localparam int BYTES_WITH_FLOAT = 5;
    localparam int BYTES_DEPTH_ONLY = 1;
    localparam int RANDOM_MAPS      = 1150;
    localparam int STALL_LIMIT      = 500;
    localparam int TAIL_CYCLES      = 12;
    localparam int MAX_REPORTS      = 40;

    // one map waiting to be sent, with its idle gap and drain request
    typedef struct {
        logic [MAP_W-1:0]  occupancy;
        logic [TYPE_W-1:0] liquid_type;
        bit                drain_first;
        int                gap_after;
    } t_map_item;

    // expected contents of one result beat
    typedef struct {
        logic [POS_W-1:0]   box_x;
        logic [POS_W-1:0]   box_z;
        logic [SPAN_W-1:0]  box_width;
        logic [SPAN_W-1:0]  box_height;
        logic               all_filled;
        logic               grid_empty;
        logic               mask_present;
        logic [MAP_W-1:0]   packed_mask;
        logic [BYTES_W-1:0] heightmap_bytes;
    } t_box_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic [MAP_W-1:0]    i_occupancy = '0;
    logic [TYPE_W-1:0]   i_liquid_type = '0;
    logic                busy;
    logic                o_strobe;
    logic [POS_W-1:0]    o_box_x;
    logic [POS_W-1:0]    o_box_z;
    logic [SPAN_W-1:0]   o_box_width;
    logic [SPAN_W-1:0]   o_box_height;
    logic                o_all_filled;
    logic                o_grid_empty;
    logic                o_mask_present;
    logic [MAP_W-1:0]    o_packed_mask;
    logic [BYTES_W-1:0]  o_heightmap_bytes;

    t_map_item   pending_maps[$];
    t_box_result expected_boxes[$];

    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int gap_left      = 0;
    int idle_cycles   = 0;
    int seen_empty    = 0;
    int seen_full     = 0;
    int seen_masked   = 0;
    int seen_depth    = 0;
    bit drv_took;
    int drv_total;
    t_map_item   drv_next;
    t_box_result mon_want;

    occupancy_box_and_mask_pack dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_occupancy       (i_occupancy),
        .i_liquid_type     (i_liquid_type),
        .o_strobe          (o_strobe),
        .o_box_x           (o_box_x),
        .o_box_z           (o_box_z),
        .o_box_width       (o_box_width),
        .o_box_height      (o_box_height),
        .o_all_filled      (o_all_filled),
        .o_grid_empty      (o_grid_empty),
        .o_mask_present    (o_mask_present),
        .o_packed_mask     (o_packed_mask),
        .o_heightmap_bytes (o_heightmap_bytes)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bounding box, fill flags, packed mask and byte count of one map
    function automatic t_box_result predict_box(input logic [MAP_W-1:0] occ,
                                                input logic [TYPE_W-1:0] ltype);
        t_box_result      r;
        int               lo_x, lo_z, hi_x, hi_z, w, h, pos;
        bit               any, full;
        logic [MAP_W-1:0] packed_bits;
        lo_x = GRID_SIDE;
        lo_z = GRID_SIDE;
        hi_x = 0;
        hi_z = 0;
        w = 0;
        h = 0;
        pos = 0;
        any = 1'b0;
        full = 1'b1;
        packed_bits = '0;
        // edge search over the grid cells only
        for (int z = 0; z < GRID_SIDE; z++) begin
            for (int x = 0; x < GRID_SIDE; x++) begin
                if (occ[z*ROW_STRIDE+x]) begin
                    any = 1'b1;
                    if (x < lo_x) lo_x = x;
                    if (z < lo_z) lo_z = z;
                    if (x + 1 > hi_x) hi_x = x + 1;
                    if (z + 1 > hi_z) hi_z = z + 1;
                end else begin
                    full = 1'b0;
                end
            end
        end
        r.heightmap_bytes = '0;
        if (!any) begin
            lo_x = 0;
            lo_z = 0;
            full = 1'b0;
        end else begin
            w = hi_x - lo_x;
            h = hi_z - lo_z;
            // pack the box row by row from bit zero
            if (!full) begin
                for (int z = lo_z; z < hi_z; z++) begin
                    for (int x = lo_x; x < hi_x; x++) begin
                        if (pos < MAP_W && occ[z*ROW_STRIDE+x]) packed_bits[pos] = 1'b1;
                        pos++;
                    end
                end
            end
            r.heightmap_bytes = BYTES_W'((w + 1) * (h + 1) *
                ((ltype == NO_FLOAT_TYPE) ? BYTES_DEPTH_ONLY : BYTES_WITH_FLOAT));
        end
        r.box_x        = lo_x[POS_W-1:0];
        r.box_z        = lo_z[POS_W-1:0];
        r.box_width    = w[SPAN_W-1:0];
        r.box_height   = h[SPAN_W-1:0];
        r.all_filled   = full;
        r.grid_empty   = !any;
        r.mask_present = any && !full && (packed_bits != '0);
        r.packed_mask  = packed_bits;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [MAP_W-1:0] got,
                                   input logic [MAP_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [MAP_W-1:0] got,
                               input logic [MAP_W-1:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // idle gap after a beat: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // liquid type: the depth-only code often, its neighbours, else anything
    function automatic logic [TYPE_W-1:0] pick_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return NO_FLOAT_TYPE;
        if (r < 40) return NO_FLOAT_TYPE ^ TYPE_W'($urandom_range(1, 3));
        return TYPE_W'($urandom);
    endfunction

    // random map: box with random density, sparse, near full or raw noise
    function automatic logic [MAP_W-1:0] pick_map();
        logic [MAP_W-1:0] m;
        int               r, x0, z0, bw, bh, density, n;
        r = $urandom_range(0, 99);
        m = '0;
        if (r < 2) begin
            m = '0;
        end else if (r < 4) begin
            m = '1;
        end else if (r < 50) begin
            x0 = $urandom_range(0, GRID_SIDE - 1);
            z0 = $urandom_range(0, GRID_SIDE - 1);
            bw = $urandom_range(1, GRID_SIDE - x0);
            bh = $urandom_range(1, GRID_SIDE - z0);
            density = $urandom_range(1, 100);
            for (int z = z0; z < z0 + bh; z++) begin
                for (int x = x0; x < x0 + bw; x++) begin
                    if ($urandom_range(1, 100) <= density) m[z*ROW_STRIDE+x] = 1'b1;
                end
            end
        end else if (r < 62) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) m[$urandom_range(0, MAP_W - 1)] = 1'b1;
        end else if (r < 72) begin
            m = '1;
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) m[$urandom_range(0, MAP_W - 1)] = 1'b0;
        end else begin
            m = {$urandom, $urandom};
        end
        return m;
    endfunction

    task automatic add_map(input logic [MAP_W-1:0] occ, input logic [TYPE_W-1:0] ltype,
                           input bit drain, input int gap);
        t_map_item it;
        it.occupancy   = occ;
        it.liquid_type = ltype;
        it.drain_first = drain;
        it.gap_after   = gap;
        pending_maps.push_back(it);
    endtask

    // driver: one map per start beat, gaps and drain pauses between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            drv_took  = start && !busy;
            drv_total = items_sent + (drv_took ? 1 : 0);
            if (drv_took) items_sent <= drv_total;
            if (start && !drv_took) begin
                // busy holds the beat, keep it as it is
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_maps.size() != 0 && pending_maps[0].drain_first &&
                         drv_total > results_seen) begin
                start <= 1'b0;
            end else if (pending_maps.size() != 0) begin
                drv_next      = pending_maps.pop_front();
                i_occupancy   <= drv_next.occupancy;
                i_liquid_type <= drv_next.liquid_type;
                start         <= 1'b1;
                gap_left      <= drv_next.gap_after;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted map, check each result beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                expected_boxes.push_back(predict_box(i_occupancy, i_liquid_type));
            if (o_strobe === 1'b1) begin
                results_seen <= results_seen + 1;
                if (expected_boxes.size() == 0) begin
                    report_mismatch("beat with no map outstanding", o_packed_mask, '0);
                end else begin
                    mon_want = expected_boxes.pop_front();
                    check_field("box_x", MAP_W'(o_box_x), MAP_W'(mon_want.box_x));
                    check_field("box_z", MAP_W'(o_box_z), MAP_W'(mon_want.box_z));
                    check_field("box_width", MAP_W'(o_box_width),
                                MAP_W'(mon_want.box_width));
                    check_field("box_height", MAP_W'(o_box_height),
                                MAP_W'(mon_want.box_height));
                    check_field("all_filled", MAP_W'(o_all_filled),
                                MAP_W'(mon_want.all_filled));
                    check_field("grid_empty", MAP_W'(o_grid_empty),
                                MAP_W'(mon_want.grid_empty));
                    check_field("mask_present", MAP_W'(o_mask_present),
                                MAP_W'(mon_want.mask_present));
                    check_field("packed_mask", o_packed_mask, mon_want.packed_mask);
                    check_field("heightmap_bytes", MAP_W'(o_heightmap_bytes),
                                MAP_W'(mon_want.heightmap_bytes));
                    if (mon_want.grid_empty) seen_empty++;
                    if (mon_want.all_filled) seen_full++;
                    if (mon_want.mask_present) seen_masked++;
                    if (!mon_want.grid_empty &&
                        mon_want.heightmap_bytes == (mon_want.box_width + 1) *
                                                    (mon_want.box_height + 1))
                        seen_depth++;
                end
            end
        end
    end

    // watchdog on cycles with no beat in either direction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe === 1'b1) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] no beat for %0d cycles", $time, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        bit flat_run;
        // directed maps: empty, full, corners, edges, checkerboards
        add_map(64'h0, 16'h0, 1'b0, 0);
        add_map('1, 16'h0, 1'b0, 0);
        add_map('1, NO_FLOAT_TYPE, 1'b0, 2);
        add_map(64'h0, NO_FLOAT_TYPE, 1'b1, 0);
        add_map(64'h1, 16'hFFFF, 1'b0, 0);
        add_map(64'h8000_0000_0000_0000, NO_FLOAT_TYPE, 1'b0, 1);
        add_map(64'h0000_0000_0000_0080, 16'h0001, 1'b0, 0);
        add_map(64'h0100_0000_0000_0000, 16'h0003, 1'b0, 0);
        add_map(64'h8000_0000_0000_0001, 16'h8000, 1'b0, 5);
        add_map(64'h0000_0000_0000_00FF, NO_FLOAT_TYPE, 1'b0, 0);
        add_map(64'hFF00_0000_0000_0000, 16'h0005, 1'b0, 0);
        add_map(64'h0101_0101_0101_0101, 16'h0000, 1'b0, 0);
        add_map(64'h8080_8080_8080_8080, NO_FLOAT_TYPE, 1'b0, 3);
        add_map(64'hFFFF_FFFF_FFFF_FFFE, 16'h7FFF, 1'b0, 0);
        add_map(64'h7FFF_FFFF_FFFF_FFFF, NO_FLOAT_TYPE, 1'b0, 0);
        add_map(64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA, 1'b0, 0);
        add_map(64'h5555_5555_5555_5555, 16'h5555, 1'b0, 0);
        add_map(64'h0000_0018_1800_0000, NO_FLOAT_TYPE, 1'b0, 0);
        add_map(64'h0000_0010_0000_0000, 16'hFFFE, 1'b0, 0);
        add_map(64'h0000_0000_0001_0080, 16'h0001, 1'b0, 0);
        add_map(64'h0000_0000_0001_0080, 16'h0001, 1'b0, 0);
        // random maps in runs, some runs with no idle gaps at all
        flat_run = 1'b0;
        for (int i = 0; i < RANDOM_MAPS; i++) begin
            if (i % 50 == 0) flat_run = ($urandom_range(0, 3) == 0);
            add_map(pick_map(), pick_type(), (i == 0) || ($urandom_range(0, 99) == 0),
                    flat_run ? 0 : pick_gap());
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_maps.size() != 0 || start || results_seen < items_sent);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_boxes.size() != 0)
            report_mismatch("results never seen", '0, MAP_W'(expected_boxes.size()));

        $display("sent %0d maps, checked %0d results, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("covered %0d empty, %0d full, %0d packed-mask and %0d depth-only grids",
                 seen_empty, seen_full, seen_masked, seen_depth);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
